[hdl/hspf_pkg.sv]
package hspf_pkg;

  // apb address width: seven 32-bit registers at 4*i
  localparam int unsigned PaddrW = 5;
  localparam int unsigned WinDepth = 7;

  typedef logic [7:0] octet_t;

  // register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_SYNC      = 3'd0,
    REG_VERSION   = 3'd1,
    REG_DATA_TYPE = 3'd2,
    REG_DATA_TAG  = 3'd3,
    REG_LINK_TYPE = 3'd4,
    REG_LINK_TAG  = 3'd5,
    REG_PKT_LEN   = 3'd6
  } reg_idx_e;

  // reset values
  localparam octet_t SyncRst     = 8'hA5;
  localparam octet_t VersionRst  = 8'h01;
  localparam octet_t DataTypeRst = 8'h10;
  localparam octet_t DataTagRst  = 8'h02;
  localparam octet_t LinkTypeRst = 8'h20;
  localparam octet_t LinkTagRst  = 8'h80;
  localparam octet_t PktLenRst   = 8'd48;

  // header matching fields
  typedef struct packed {
    octet_t sync_byte;
    octet_t version_byte;
    octet_t data_type_byte;
    octet_t data_tag_byte;
    octet_t link_type_byte;
    octet_t link_tag_byte;
  } hdr_cfg_t;

endpackage

[hdl/hspf_hdr_match.sv]
module hspf_hdr_match
  import hspf_pkg::*;
(
  input  hdr_cfg_t cfg_i,
  input  octet_t   win_i [WinDepth],
  output logic     hit_o
);

  logic common_ok;
  logic data_ok;
  logic link_ok;

  // sync, sync and version are shared by both header kinds
  assign common_ok = (win_i[0] == cfg_i.sync_byte) && (win_i[1] == cfg_i.sync_byte)
                  && (win_i[3] == cfg_i.version_byte);
  assign data_ok   = (win_i[2] == cfg_i.data_type_byte) && (win_i[6] == cfg_i.data_tag_byte);
  assign link_ok   = (win_i[2] == cfg_i.link_type_byte) && (win_i[6] == cfg_i.link_tag_byte);
  assign hit_o     = common_ok && (data_ok || link_ok);

endmodule

[hdl/header_sync_packet_framer.sv]
// Sync-header packet framer. Takes one stream byte per cycle on the slave side and keeps
// the last seven bytes in a shift window. While hunting, a data or link header starting
// at the oldest window byte opens a packet of packet_length bytes (a length of zero
// gives one byte), sent on the master side with tuser marking the header byte and tlast
// the final byte; bytes inside a packet are not searched. Packet bytes trail the input
// by six bytes, the first six bytes after reset only fill the window, and non-packet
// bytes are dropped. The header compare and the byte counter sit between the window
// register and the output register, so a new word is taken every cycle unless the output
// register holds a word the sink has not taken.
// Registers are written through the APB port at byte address 4*index and read back
// there; write them only while the stream is idle.
module header_sync_packet_framer
  import hspf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // slave stream
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,   // [7:0] stream_byte
  // master stream
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [7:0]        m_axis_tdata_o,   // [7:0] packet_byte
  output logic [0:0]        m_axis_tuser_o,   // [0] first_flag
  output logic              m_axis_tlast_o,   // last_flag
  // apb configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  hdr_cfg_t cfg_q;
  octet_t   pkt_len_q;

  octet_t   win_q [WinDepth];
  octet_t   win_d [WinDepth];
  logic [2:0] fill_q, fill_d;
  logic     collect_q, collect_d;
  octet_t   left_q, left_d;

  logic     out_valid_q;
  octet_t   out_byte_q;
  logic     out_first_q, out_last_q;

  logic     in_acc;
  logic     win_full;
  logic     hit;
  logic     emit, first_d, last_d;
  octet_t   left_dec;
  reg_idx_e reg_idx;

  // apb register file
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_byte      <= SyncRst;
      cfg_q.version_byte   <= VersionRst;
      cfg_q.data_type_byte <= DataTypeRst;
      cfg_q.data_tag_byte  <= DataTagRst;
      cfg_q.link_type_byte <= LinkTypeRst;
      cfg_q.link_tag_byte  <= LinkTagRst;
      pkt_len_q            <= PktLenRst;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_SYNC:      cfg_q.sync_byte      <= pwdata[7:0];
        REG_VERSION:   cfg_q.version_byte   <= pwdata[7:0];
        REG_DATA_TYPE: cfg_q.data_type_byte <= pwdata[7:0];
        REG_DATA_TAG:  cfg_q.data_tag_byte  <= pwdata[7:0];
        REG_LINK_TYPE: cfg_q.link_type_byte <= pwdata[7:0];
        REG_LINK_TAG:  cfg_q.link_tag_byte  <= pwdata[7:0];
        REG_PKT_LEN:   pkt_len_q            <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_SYNC:      prdata[7:0] = cfg_q.sync_byte;
      REG_VERSION:   prdata[7:0] = cfg_q.version_byte;
      REG_DATA_TYPE: prdata[7:0] = cfg_q.data_type_byte;
      REG_DATA_TAG:  prdata[7:0] = cfg_q.data_tag_byte;
      REG_LINK_TYPE: prdata[7:0] = cfg_q.link_type_byte;
      REG_LINK_TAG:  prdata[7:0] = cfg_q.link_tag_byte;
      REG_PKT_LEN:   prdata[7:0] = pkt_len_q;
      default:       prdata      = '0;
    endcase
  end

  // stream handshake: take a word unless the output register is stalled
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // window after this word shifts in at the young end
  always_comb begin
    for (int i = 0; i < WinDepth - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[WinDepth-1] = s_axis_tdata_i;
  end

  // window is complete once six words were held before this one
  assign win_full = (fill_q >= 3'(WinDepth - 1));
  assign fill_d   = win_full ? 3'(WinDepth) : fill_q + 3'd1;

  hspf_hdr_match u_match (
    .cfg_i (cfg_q),
    .win_i (win_d),
    .hit_o (hit)
  );

  // framing control
  assign left_dec = (left_q != 8'd0) ? left_q - 8'd1 : 8'd0;

  always_comb begin
    emit      = 1'b0;
    first_d   = 1'b0;
    last_d    = 1'b0;
    collect_d = collect_q;
    left_d    = left_q;
    if (win_full) begin
      if (collect_q) begin
        emit   = 1'b1;
        left_d = left_dec;
        if (left_dec == 8'd0) begin
          last_d    = 1'b1;
          collect_d = 1'b0;
        end
      end else if (hit) begin
        emit    = 1'b1;
        first_d = 1'b1;
        if (pkt_len_q <= 8'd1) begin
          last_d = 1'b1;
          left_d = 8'd0;
        end else begin
          left_d    = pkt_len_q - 8'd1;
          collect_d = 1'b1;
        end
      end
    end
  end

  // window and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      collect_q <= 1'b0;
      left_q    <= '0;
    end else if (in_acc) begin
      fill_q    <= fill_d;
      collect_q <= collect_d;
      left_q    <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      win_q <= win_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= emit;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      out_byte_q  <= win_d[0];
      out_first_q <= first_d;
      out_last_q  <= last_d;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_byte_q;
  assign m_axis_tuser_o[0] = out_first_q;
  assign m_axis_tlast_o    = out_last_q;

endmodule

[hdl/hspf_checker.sv]
module hspf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [0:0] m_axis_tuser_o,
  input logic       m_axis_tlast_o,
  input logic       pready
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("stalled output word changed");

  // input is held off while the output register is stalled
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while output stalled");

  // a new output word only follows an accepted input word
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("output word without input word");

  // output register drains when the sink takes it and nothing new arrives
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !s_axis_tvalid_i |=> !m_axis_tvalid_o)
    else $error("output word repeated");

  // config port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind header_sync_packet_framer hspf_checker u_hspf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .pready          (pready)
);
